>>> rtl/racp_pkg.sv
`timescale 1ns / 1ps

package racp_pkg;

	// Field widths of the pixel channel and the register port.
	localparam int COORD_W    = 9;
	localparam int RADIUS_W   = 8;
	localparam int ALPHA_W    = 8;
	localparam int COLOR_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// The squared distance is below 2^20, so the root walks ten bit pairs of it.
	localparam int SQ_PAIRS = 10;
	localparam int SQ_W     = 2 * SQ_PAIRS;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW = 2'd1;

	// Reset value of the radius register.
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 8'd8;

	// White pixel with the alpha byte left open at the top or at the bottom.
	localparam logic [COLOR_W-1:0] WHITE_ALPHA_TOP = 32'h00FF_FFFF;
	localparam logic [COLOR_W-1:0] WHITE_ALPHA_LOW = 32'hFFFF_FF00;

endpackage

>>> rtl/racp_sqrt.sv
`timescale 1ns / 1ps

// Pipelined restoring square root: one result bit per stage. The root carries
// FRAC_BITS fraction bits, so the radicand is walked as ten pairs followed by
// FRAC_BITS zero pairs.
module racp_sqrt #(
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [racp_pkg::SQ_W-1:0]  sq,
	output logic                       out_valid,
	output logic [racp_pkg::SQ_PAIRS+FRAC_BITS-1:0] root
);

	localparam int NS = racp_pkg::SQ_PAIRS + FRAC_BITS;
	localparam int RW = NS + 2;
	localparam int SW = racp_pkg::SQ_W;

	// Stage outputs; the radicand and remainder are not needed after the last stage.
	logic [SW-1:0] sq_s   [NS-1];
	logic [RW-1:0] rem_s  [NS-1];
	logic [NS-1:0] root_s [NS];
	logic          vld_s  [NS];

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [SW-1:0] sq_in;
		logic [RW-1:0] rem_in;
		logic [NS-1:0] root_in;
		logic          v_in;
		logic [RW-1:0] rem_sh;
		logic [RW-1:0] trial;
		logic          take;

		if (g == 0) begin : g_first
			assign sq_in   = sq;
			assign rem_in  = '0;
			assign root_in = '0;
			assign v_in    = in_valid;
		end else begin : g_next
			assign sq_in   = sq_s[g-1];
			assign rem_in  = rem_s[g-1];
			assign root_in = root_s[g-1];
			assign v_in    = vld_s[g-1];
		end

		// Bring down the next pair and try to subtract 4*root+1.
		assign rem_sh = {rem_in[RW-3:0], sq_in[SW-1:SW-2]};
		assign trial  = {root_in, 2'b01};
		assign take   = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[g] <= {root_in[NS-2:0], take};
			end
		end

		if (g < NS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					sq_s[g]  <= {sq_in[SW-3:0], 2'b00};
					rem_s[g] <= take ? (rem_sh - trial) : rem_sh;
				end
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign root      = root_s[NS-1];

endmodule

>>> rtl/racp_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider by the radius: one quotient bit per stage. The
// dividend shifts out at the top of a register while quotient bits shift in
// at the bottom, so the same register ends up holding the quotient.
module racp_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    in_valid,
	input  logic [racp_pkg::SQ_PAIRS+FRAC_BITS-1:0] dividend,
	input  logic [racp_pkg::RADIUS_W-1:0]           divisor,
	output logic                                    out_valid,
	output logic [racp_pkg::SQ_PAIRS+FRAC_BITS-1:0] quotient
);

	localparam int NS = racp_pkg::SQ_PAIRS + FRAC_BITS;
	localparam int RW = racp_pkg::RADIUS_W;

	logic [NS-1:0] dq_s  [NS];
	logic [RW-1:0] rem_s [NS-1];
	logic          vld_s [NS];

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [NS-1:0] dq_in;
		logic [RW-1:0] rem_in;
		logic          v_in;
		logic [RW:0]   rem_sh;
		logic [RW:0]   diff;
		logic          take;

		if (g == 0) begin : g_first
			assign dq_in  = dividend;
			assign rem_in = '0;
			assign v_in   = in_valid;
		end else begin : g_next
			assign dq_in  = dq_s[g-1];
			assign rem_in = rem_s[g-1];
			assign v_in   = vld_s[g-1];
		end

		// The partial remainder stays below the divisor, so it fits in eight bits.
		assign rem_sh = {rem_in, dq_in[NS-1]};
		assign diff   = rem_sh - {1'b0, divisor};
		assign take   = (rem_sh >= {1'b0, divisor});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dq_s[g] <= {dq_in[NS-2:0], take};
			end
		end

		if (g < NS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g] <= take ? diff[RW-1:0] : rem_sh[RW-1:0];
				end
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign quotient  = dq_s[NS-1];

endmodule

>>> rtl/racp_shade.sv
`timescale 1ns / 1ps

// Turns the normalized distance into alpha in two stages: scale by 0.9, then
// the clipped ramp and the scale to 0..255.
module racp_shade #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    in_valid,
	input  logic [racp_pkg::SQ_PAIRS+FRAC_BITS-1:0] quo,
	input  logic                                    r_zero,
	output logic                                    out_valid,
	output logic [racp_pkg::ALPHA_W-1:0]            alpha
);

	localparam int NS = racp_pkg::SQ_PAIRS + FRAC_BITS;
	localparam int PW = 2 * FRAC_BITS + 1;
	localparam int TW = FRAC_BITS + 1 + racp_pkg::ALPHA_W;

	// The constant 0.9 and the unit value in fixed point.
	localparam logic [FRAC_BITS-1:0] KNINE =
		FRAC_BITS'((64'd9 << FRAC_BITS) / 64'd10);
	localparam logic [FRAC_BITS:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [FRAC_BITS:0] KNEE = ONE >> 3;

	logic [FRAC_BITS:0]          q_clip;
	logic [PW-1:0]               prod_c;
	logic [PW-1:0]               prod_s1;
	logic                        vld_s1;
	logic [FRAC_BITS:0]          p_c;
	logic [FRAC_BITS:0]          diff_c;
	logic [FRAC_BITS:0]          t_c;
	logic [TW-1:0]               t255_c;
	logic [racp_pkg::ALPHA_W-1:0] alpha_c;
	logic [racp_pkg::ALPHA_W-1:0] alpha_s2;
	logic                        vld_s2;

	// Any quotient of two or more already drives the ramp to zero, so clip it
	// to keep the multiplier narrow.
	assign q_clip = (|quo[NS-1:FRAC_BITS+1]) ? '1 : quo[FRAC_BITS:0];
	assign prod_c = PW'(KNINE) * PW'(q_clip);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= prod_c;
			alpha_s2 <= alpha_c;
		end
	end

	// Ramp t = min(8 * (1 - p), 1), zero once p reaches one, then alpha = t * 255.
	always_comb begin
		p_c    = prod_s1[PW-1:FRAC_BITS];
		diff_c = ONE - p_c;
		if (p_c[FRAC_BITS]) begin
			t_c = '0;
		end else if (diff_c > KNEE) begin
			t_c = ONE;
		end else begin
			t_c = {diff_c[FRAC_BITS-3:0], 3'b000};
		end
		t255_c = {t_c, {racp_pkg::ALPHA_W{1'b0}}} - TW'(t_c);
		if (r_zero) begin
			alpha_c = '0;
		end else begin
			alpha_c = t255_c[FRAC_BITS+racp_pkg::ALPHA_W-1:FRAC_BITS];
		end
	end

	assign out_valid = vld_s2;
	assign alpha     = alpha_s2;

endmodule

>>> rtl/radial_alpha_corner_pixel.sv
`timescale 1ns / 1ps

// Radial alpha pixel generator for a rounded-corner sprite.
// Input channel: pixel_x and pixel_y with in_valid; the block drives in_stall.
// A beat is taken at a clock edge with in_valid high and in_stall low.
// Output channel: alpha_value and packed_color with out_valid; the receiver
// drives out_stall, and a beat leaves at an edge with out_valid high and
// out_stall low. Every input beat gives exactly one output beat, in order.
// Configuration: cfg_index and cfg_data with cfg_valid and cfg_ready (always
// ready); index 0 is the radius, index 1 moves alpha to the low byte. Write
// registers only while no pixel is in flight.
// Throughput is one pixel per clock while the output is not stalled. An input
// beat passes through two front stages, one stage per root bit, one stage per
// quotient bit, two shading stages and the output register.
// While the output beat is stalled the whole pipeline holds; one more input
// beat is taken into a skid register, after which in_stall rises until the
// pipeline moves again.
// Reset clears all valid bits, including the skid register's, sets the radius
// to 8 and puts alpha in the top byte.
module radial_alpha_corner_pixel #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [racp_pkg::COORD_W-1:0]      pixel_x,
	input  logic [racp_pkg::COORD_W-1:0]      pixel_y,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [racp_pkg::ALPHA_W-1:0]      alpha_value,
	output logic [racp_pkg::COLOR_W-1:0]      packed_color,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [racp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [racp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int NS = racp_pkg::SQ_PAIRS + FRAC_BITS;
	localparam int CW = racp_pkg::COORD_W;

	logic [racp_pkg::RADIUS_W-1:0] radius_q;
	logic                          alpha_low_byte_q;

	logic                          en;
	logic                          in_take;
	logic                          skid_valid_q;
	logic [CW-1:0]                 skid_x_q;
	logic [CW-1:0]                 skid_y_q;
	logic                          f_valid;
	logic [CW-1:0]                 f_x;
	logic [CW-1:0]                 f_y;
	logic [CW-1:0]                 r_ext;
	logic [CW-1:0]                 dx_c;
	logic [CW-1:0]                 dy_c;

	logic                          vld_s1;
	logic [CW-1:0]                 dx_s1;
	logic [CW-1:0]                 dy_s1;
	logic                          vld_s2;
	logic [racp_pkg::SQ_W-1:0]     sq_s2;

	logic                          root_valid;
	logic [NS-1:0]                 root;
	logic                          quo_valid;
	logic [NS-1:0]                 quo;
	logic                          shade_valid;
	logic [racp_pkg::ALPHA_W-1:0]  shade_alpha;

	logic                          out_valid_q;
	logic [racp_pkg::ALPHA_W-1:0]  alpha_value_q;
	logic [racp_pkg::COLOR_W-1:0]  packed_color_q;

	// Register writes.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q         <= racp_pkg::RADIUS_RESET;
			alpha_low_byte_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				racp_pkg::REG_RADIUS:    radius_q <= cfg_data[racp_pkg::RADIUS_W-1:0];
				racp_pkg::REG_ALPHA_LOW: alpha_low_byte_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The pipeline moves unless a finished beat sits stalled at the output.
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = skid_valid_q;
	assign in_take  = in_valid && !skid_valid_q;

	// Skid register catches the beat taken while the pipeline holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (en) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_take && !en) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && !en) begin
			skid_x_q <= pixel_x;
			skid_y_q <= pixel_y;
		end
	end

	assign f_valid = skid_valid_q || in_valid;
	assign f_x     = skid_valid_q ? skid_x_q : pixel_x;
	assign f_y     = skid_valid_q ? skid_y_q : pixel_y;

	// Stage 1: offsets from the centre.
	assign r_ext = CW'(radius_q);
	assign dx_c  = (f_x >= r_ext) ? (f_x - r_ext) : (r_ext - f_x);
	assign dy_c  = (f_y >= r_ext) ? (f_y - r_ext) : (r_ext - f_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= f_valid;
			vld_s2 <= vld_s1;
		end
	end

	// Stage 2: squared distance.
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= dx_c;
			dy_s1 <= dy_c;
			sq_s2 <= racp_pkg::SQ_W'(dx_s1 * dx_s1) + racp_pkg::SQ_W'(dy_s1 * dy_s1);
		end
	end

	racp_sqrt #(
		.FRAC_BITS (FRAC_BITS)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s2),
		.sq        (sq_s2),
		.out_valid (root_valid),
		.root      (root)
	);

	racp_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (root_valid),
		.dividend  (root),
		.divisor   (radius_q),
		.out_valid (quo_valid),
		.quotient  (quo)
	);

	racp_shade #(
		.FRAC_BITS (FRAC_BITS)
	) u_shade (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (quo_valid),
		.quo       (quo),
		.r_zero    (radius_q == '0),
		.out_valid (shade_valid),
		.alpha     (shade_alpha)
	);

	// Output register with the alpha byte placed per byte order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= shade_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_value_q <= shade_alpha;
			if (alpha_low_byte_q) begin
				packed_color_q <= racp_pkg::WHITE_ALPHA_LOW |
					racp_pkg::COLOR_W'(shade_alpha);
			end else begin
				packed_color_q <= racp_pkg::WHITE_ALPHA_TOP |
					{shade_alpha, {(racp_pkg::COLOR_W - racp_pkg::ALPHA_W){1'b0}}};
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign alpha_value  = alpha_value_q;
	assign packed_color = packed_color_q;

`ifndef SYNTH
	// A beat taken while the pipeline holds must land in the skid register.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !en) |=> skid_valid_q)
		else $error("beat taken during hold was not caught by the skid register");

	// Once the pipeline moves, the skid register is empty in the following cycle.
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && en) |=> !skid_valid_q)
		else $error("skid register did not drain when the pipeline moved");

	// The skid register only fills while the pipeline is held.
	a_skid_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(!en))
		else $error("skid register filled while the pipeline was moving");
`endif

endmodule
